// File: rtl/saes_pkg.sv
`timescale 1ns / 1ps

package saes_pkg;

  typedef logic [3:0]  nib_t;
  typedef logic [7:0]  word_t;
  typedef logic [15:0] blk_t;

  // Round keys derived from the cipher key
  typedef struct packed {
    blk_t k0;
    blk_t k1;
    blk_t k2;
  } saes_rkeys_t;

  // Action codes
  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  // Key schedule round constants
  localparam word_t RCON_1 = 8'h80;
  localparam word_t RCON_2 = 8'h30;

  // Reduction term for x^4 = x + 1
  localparam nib_t GF_REDUCE = 4'h3;

  // MixColumns matrix entries, forward and inverse
  localparam nib_t MIX_FWD_DIAG = 4'h1;
  localparam nib_t MIX_FWD_OFF  = 4'h4;
  localparam nib_t MIX_INV_DIAG = 4'h9;
  localparam nib_t MIX_INV_OFF  = 4'h2;

  localparam nib_t SBOX_FWD [16] = '{
    4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
    4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
  };

  localparam nib_t SBOX_INV [16] = '{
    4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
    4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE
  };

  // Multiply in GF(16) modulo x^4 + x + 1
  function automatic nib_t gf_mul(input nib_t a, input nib_t b);
    nib_t acc;
    nib_t sh;
    acc = '0;
    sh  = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) acc = acc ^ sh;
      sh = {sh[2:0], 1'b0} ^ (sh[3] ? GF_REDUCE : 4'h0);
    end
    return acc;
  endfunction

  function automatic blk_t sub_fwd(input blk_t s);
    return {SBOX_FWD[s[15:12]], SBOX_FWD[s[11:8]], SBOX_FWD[s[7:4]], SBOX_FWD[s[3:0]]};
  endfunction

  function automatic blk_t sub_inv(input blk_t s);
    return {SBOX_INV[s[15:12]], SBOX_INV[s[11:8]], SBOX_INV[s[7:4]], SBOX_INV[s[3:0]]};
  endfunction

  // Swap the second and fourth nibble
  function automatic blk_t shift_rows(input blk_t s);
    return {s[15:12], s[3:0], s[7:4], s[11:8]};
  endfunction

  // Multiply each column by [[d, o], [o, d]]
  function automatic blk_t mix_cols(input blk_t s, input nib_t d, input nib_t o);
    nib_t m0;
    nib_t m1;
    nib_t m2;
    nib_t m3;
    m0 = gf_mul(d, s[15:12]) ^ gf_mul(o, s[11:8]);
    m1 = gf_mul(o, s[15:12]) ^ gf_mul(d, s[11:8]);
    m2 = gf_mul(d, s[7:4])   ^ gf_mul(o, s[3:0]);
    m3 = gf_mul(o, s[7:4])   ^ gf_mul(d, s[3:0]);
    return {m0, m1, m2, m3};
  endfunction

  function automatic word_t key_g(input word_t w, input word_t rc);
    return {SBOX_FWD[w[3:0]], SBOX_FWD[w[7:4]]} ^ rc;
  endfunction

  function automatic saes_rkeys_t expand_key(input blk_t key);
    word_t w2;
    word_t w3;
    word_t w4;
    word_t w5;
    saes_rkeys_t rk;
    w2 = key[15:8] ^ key_g(key[7:0], RCON_1);
    w3 = w2 ^ key[7:0];
    w4 = w2 ^ key_g(w3, RCON_2);
    w5 = w4 ^ w3;
    rk.k0 = key;
    rk.k1 = {w2, w3};
    rk.k2 = {w4, w5};
    return rk;
  endfunction

endpackage

// File: rtl/saes_key_sched.sv
`timescale 1ns / 1ps

module saes_key_sched
  import saes_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  blk_t        cfg_data_i,
  output saes_rkeys_t rkeys_o
);

  saes_rkeys_t rkeys_d;
  saes_rkeys_t rkeys_q;

  // Expand a new key on each configuration transaction, hold otherwise
  always_comb begin
    rkeys_d = rkeys_q;
    if (cfg_valid_i) rkeys_d = expand_key(cfg_data_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rkeys_q <= expand_key(16'h0000);
    end else begin
      rkeys_q <= rkeys_d;
    end
  end

  assign rkeys_o = rkeys_q;

endmodule

// File: rtl/simplified_aes_block_cipher.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// command   in         start & !busy              action_i, block_in_i
// result    out        done_o (one cycle strobe)  block_out_o
// config    in         cfg_valid_i & cfg_ready_o  cfg_data_i
//
// Three register stages: key add and substitution, mix and key add, final round.
// An accepted block moves through the valid bits v1_q, v2_q and v3_q; done_o is v3_q
// and rises with its result in s3_q; one block may start every cycle, busy stays low.
// The round keys are expanded and registered at the key write itself.
// rst_ni clears the stage valid bits and loads the round keys of key zero.
// The result side cannot stall, so the pipeline never holds.

module simplified_aes_block_cipher
  import saes_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [15:0] block_in_i,
  output logic        done_o,
  output logic [15:0] block_out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  saes_rkeys_t rkeys;

  logic accept;
  logic v1_q, v2_q, v3_q;
  logic a1_q, a2_q;
  blk_t s1_d, s2_d, s3_d;
  blk_t s1_q, s2_q, s3_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start & ~busy;

  saes_key_sched u_key_sched (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .rkeys_o     (rkeys)
  );

  // Initial key add and first substitution
  always_comb begin
    unique case (action_i)
      ACT_ENCRYPT: s1_d = sub_fwd(block_in_i ^ rkeys.k0);
      ACT_DECRYPT: s1_d = sub_inv(shift_rows(block_in_i ^ rkeys.k2));
      default:     s1_d = sub_fwd(block_in_i ^ rkeys.k0);
    endcase
  end

  // Mix columns and middle key add
  always_comb begin
    unique case (a1_q)
      ACT_ENCRYPT:
        s2_d = mix_cols(shift_rows(s1_q), MIX_FWD_DIAG, MIX_FWD_OFF) ^ rkeys.k1;
      ACT_DECRYPT:
        s2_d = mix_cols(s1_q ^ rkeys.k1, MIX_INV_DIAG, MIX_INV_OFF);
      default:
        s2_d = s1_q;
    endcase
  end

  // Final round
  always_comb begin
    unique case (a2_q)
      ACT_ENCRYPT: s3_d = shift_rows(sub_fwd(s2_q)) ^ rkeys.k2;
      ACT_DECRYPT: s3_d = sub_inv(shift_rows(s2_q)) ^ rkeys.k0;
      default:     s3_d = s2_q;
    endcase
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    a1_q <= action_i;
    s2_q <= s2_d;
    a2_q <= a1_q;
    s3_q <= s3_d;
  end

  assign done_o      = v3_q;
  assign block_out_o = s3_q;

endmodule
